[hw/rtl/sxd_pkg.sv]
// Shared types, constants and the opcode table for the SIC/XE instruction decoder.
package sxd_pkg;

    localparam int unsigned MNEM_BITS = 6;
    localparam logic [7:0] OPCODE_MASK = 8'hFC;
    localparam logic [MNEM_BITS-1:0] LDB_INDEX = 6'd20;

    typedef enum logic [1:0] {
        FMT_CLASS_NONE = 2'd0,
        FMT_CLASS_ONE  = 2'd1,
        FMT_CLASS_TWO  = 2'd2,
        FMT_CLASS_MEM  = 2'd3
    } fmt_class_t;

    typedef enum logic [2:0] {
        FORMAT_UNKNOWN = 3'd0,
        FORMAT_1       = 3'd1,
        FORMAT_2       = 3'd2,
        FORMAT_3       = 3'd3,
        FORMAT_4       = 3'd4
    } format_code_t;

    typedef enum logic [1:0] {
        OPM_NONE      = 2'd0,
        OPM_SIMPLE    = 2'd1,
        OPM_IMMEDIATE = 2'd2,
        OPM_INDIRECT  = 2'd3
    } operand_mode_t;

    typedef enum logic [2:0] {
        TGT_NONE     = 3'd0,
        TGT_ABSOLUTE = 3'd1,
        TGT_PC_REL   = 3'd2,
        TGT_BASE_REL = 3'd3,
        TGT_INVALID  = 3'd4
    } target_mode_t;

    typedef struct packed {
        logic                 found;
        logic [MNEM_BITS-1:0] index;
        fmt_class_t           fmt_class;
    } opcode_entry_t;

    // Everything the decoder reports except the address, which has a parameter width.
    typedef struct packed {
        logic                 known;
        logic [MNEM_BITS-1:0] mnemonic;
        format_code_t         format_code;
        logic [2:0]           length;
        operand_mode_t        operand_mode;
        target_mode_t         target_mode;
        logic                 indexed;
        logic [3:0]           reg_one;
        logic [3:0]           reg_two;
        logic                 base_load;
    } decode_result_t;

    // Opcode table in alphabetical mnemonic order, ADD at position 0 to WD at 58.
    function automatic opcode_entry_t opcode_lookup(input logic [7:0] opcode_byte);
        opcode_entry_t e;
        e.found     = 1'b1;
        e.index     = '0;
        e.fmt_class = FMT_CLASS_MEM;
        unique case (opcode_byte & OPCODE_MASK)
            8'h18: e.index = 6'd0;
            8'h58: e.index = 6'd1;
            8'h90: begin e.index = 6'd2;  e.fmt_class = FMT_CLASS_TWO; end
            8'h40: e.index = 6'd3;
            8'hB4: begin e.index = 6'd4;  e.fmt_class = FMT_CLASS_TWO; end
            8'h28: e.index = 6'd5;
            8'h88: e.index = 6'd6;
            8'hA0: begin e.index = 6'd7;  e.fmt_class = FMT_CLASS_TWO; end
            8'h24: e.index = 6'd8;
            8'h64: e.index = 6'd9;
            8'h9C: begin e.index = 6'd10; e.fmt_class = FMT_CLASS_TWO; end
            8'hC4: begin e.index = 6'd11; e.fmt_class = FMT_CLASS_ONE; end
            8'hC0: begin e.index = 6'd12; e.fmt_class = FMT_CLASS_ONE; end
            8'hF4: begin e.index = 6'd13; e.fmt_class = FMT_CLASS_ONE; end
            8'h3C: e.index = 6'd14;
            8'h30: e.index = 6'd15;
            8'h34: e.index = 6'd16;
            8'h38: e.index = 6'd17;
            8'h48: e.index = 6'd18;
            8'h00: e.index = 6'd19;
            8'h68: e.index = LDB_INDEX;
            8'h50: e.index = 6'd21;
            8'h70: e.index = 6'd22;
            8'h08: e.index = 6'd23;
            8'h6C: e.index = 6'd24;
            8'h74: e.index = 6'd25;
            8'h04: e.index = 6'd26;
            8'hD0: e.index = 6'd27;
            8'h20: e.index = 6'd28;
            8'h60: e.index = 6'd29;
            8'h98: begin e.index = 6'd30; e.fmt_class = FMT_CLASS_TWO; end
            8'hC8: begin e.index = 6'd31; e.fmt_class = FMT_CLASS_ONE; end
            8'h44: e.index = 6'd32;
            8'hD8: e.index = 6'd33;
            8'hAC: begin e.index = 6'd34; e.fmt_class = FMT_CLASS_TWO; end
            8'h4C: e.index = 6'd35;
            8'hA4: begin e.index = 6'd36; e.fmt_class = FMT_CLASS_TWO; end
            8'hA8: begin e.index = 6'd37; e.fmt_class = FMT_CLASS_TWO; end
            8'hF0: begin e.index = 6'd38; e.fmt_class = FMT_CLASS_ONE; end
            8'hEC: e.index = 6'd39;
            8'h0C: e.index = 6'd40;
            8'h78: e.index = 6'd41;
            8'h54: e.index = 6'd42;
            8'h80: e.index = 6'd43;
            8'hD4: e.index = 6'd44;
            8'h14: e.index = 6'd45;
            8'h7C: e.index = 6'd46;
            8'hE8: e.index = 6'd47;
            8'h84: e.index = 6'd48;
            8'h10: e.index = 6'd49;
            8'h1C: e.index = 6'd50;
            8'h5C: e.index = 6'd51;
            8'h94: begin e.index = 6'd52; e.fmt_class = FMT_CLASS_TWO; end
            8'hB0: begin e.index = 6'd53; e.fmt_class = FMT_CLASS_TWO; end
            8'hE0: e.index = 6'd54;
            8'hF8: begin e.index = 6'd55; e.fmt_class = FMT_CLASS_ONE; end
            8'h2C: e.index = 6'd56;
            8'hB8: begin e.index = 6'd57; e.fmt_class = FMT_CLASS_TWO; end
            8'hDC: e.index = 6'd58;
            default:
            begin
                e.found     = 1'b0;
                e.fmt_class = FMT_CLASS_NONE;
            end
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/sxd_decode.sv]
// Combinational decode of one instruction: table match, flags and target address.
module sxd_decode #(
    parameter int ADDR_BITS = 20
) (
    input  logic [ADDR_BITS-1:0]   instr_addr,
    input  logic [7:0]             byte_zero,
    input  logic [7:0]             byte_one,
    input  logic [7:0]             byte_two,
    input  logic [7:0]             byte_three,
    input  logic [ADDR_BITS-1:0]   base_value,
    output sxd_pkg::decode_result_t result,
    output logic [ADDR_BITS-1:0]   target_address
);

    // Sums are formed at least 20 bits wide so the format 4 field is never cut early.
    localparam int FW = (ADDR_BITS > 20) ? ADDR_BITS : 20;

    sxd_pkg::opcode_entry_t entry;
    logic          flag_n;
    logic          flag_i;
    logic          flag_x;
    logic          flag_b;
    logic          flag_p;
    logic          flag_e;
    logic [19:0]   field_raw;
    logic [FW-1:0] field_ext;
    logic [FW-1:0] disp_ext;
    logic [FW-1:0] pc_sum;
    logic [FW-1:0] base_sum;
    logic [FW-1:0] ta_ext;
    logic [2:0]    mem_length;

    assign entry  = sxd_pkg::opcode_lookup(byte_zero);
    assign flag_n = byte_zero[1];
    assign flag_i = byte_zero[0];
    assign flag_x = byte_one[7];
    assign flag_b = byte_one[6];
    assign flag_p = byte_one[5];
    assign flag_e = byte_one[4];

    assign mem_length = flag_e ? 3'd4 : 3'd3;
    assign field_raw  = flag_e ? {byte_one[3:0], byte_two, byte_three}
                               : {8'd0, byte_one[3:0], byte_two};
    assign field_ext  = FW'(field_raw);
    // Format 3 displacement is signed for PC-relative use only.
    assign disp_ext   = flag_e ? field_ext
                               : {{(FW-12){byte_one[3]}}, byte_one[3:0], byte_two};
    assign pc_sum     = FW'(instr_addr) + FW'(mem_length) + disp_ext;
    assign base_sum   = FW'(base_value) + field_ext;

    always_comb
    begin
        if (flag_b && flag_p) begin
            ta_ext = field_ext;
        end else if (flag_p) begin
            ta_ext = pc_sum;
        end else if (flag_b) begin
            ta_ext = base_sum;
        end else begin
            ta_ext = field_ext;
        end
    end

    always_comb
    begin
        result.known        = entry.found;
        result.mnemonic     = entry.index;
        result.format_code  = sxd_pkg::FORMAT_UNKNOWN;
        result.length       = 3'd1;
        result.operand_mode = sxd_pkg::OPM_NONE;
        result.target_mode  = sxd_pkg::TGT_NONE;
        result.indexed      = 1'b0;
        result.reg_one      = '0;
        result.reg_two      = '0;
        result.base_load    = 1'b0;
        target_address      = '0;
        unique case (entry.fmt_class)
            sxd_pkg::FMT_CLASS_ONE:
            begin
                result.format_code = sxd_pkg::FORMAT_1;
            end
            sxd_pkg::FMT_CLASS_TWO:
            begin
                result.format_code = sxd_pkg::FORMAT_2;
                result.length      = 3'd2;
                result.reg_one     = byte_one[7:4];
                result.reg_two     = byte_one[3:0];
            end
            sxd_pkg::FMT_CLASS_MEM:
            begin
                result.format_code = flag_e ? sxd_pkg::FORMAT_4 : sxd_pkg::FORMAT_3;
                result.length      = mem_length;
                if (flag_i && !flag_n) begin
                    result.operand_mode = sxd_pkg::OPM_IMMEDIATE;
                end else if (flag_n && !flag_i) begin
                    result.operand_mode = sxd_pkg::OPM_INDIRECT;
                end else begin
                    result.operand_mode = sxd_pkg::OPM_SIMPLE;
                end
                if (flag_b && flag_p) begin
                    result.target_mode = sxd_pkg::TGT_INVALID;
                end else if (flag_p) begin
                    result.target_mode = sxd_pkg::TGT_PC_REL;
                end else if (flag_b) begin
                    result.target_mode = sxd_pkg::TGT_BASE_REL;
                end else begin
                    result.target_mode = sxd_pkg::TGT_ABSOLUTE;
                end
                result.indexed   = flag_x;
                result.base_load = (entry.index == sxd_pkg::LDB_INDEX);
                target_address   = ta_ext[ADDR_BITS-1:0];
            end
            default:
            begin
                result.known    = 1'b0;
                result.mnemonic = '0;
            end
        endcase
    end

endmodule

[hw/rtl/sicxe_instruction_decoder.sv]
// Top level of the SIC/XE instruction decoder: input stage, decode, result stage, base register.
//
// The decoder takes one instruction per cycle while it is not stalled (address plus four raw
// bytes) and returns one decoded result per instruction. An instruction is captured in an
// input register, decoded by a single pass of combinational logic (a 59-entry opcode table
// match, flag decode and the PC-relative and base-relative address sums), and written into
// a result register once that register is free. Sustained throughput is one instruction per
// clock while out_ready is held high; it is set by the decode path between the two registers.
// The input register keeps accepting while a finished result waits on out_ready, until both
// registers hold an item. The base register is updated when an LDB instruction moves into
// the result register, so an instruction right behind an LDB already sees the new base
// value. Target addresses wrap modulo 2^ADDR_BITS; the index flag is reported but not
// applied to the address.
module sicxe_instruction_decoder #(
    parameter int ADDR_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_BITS-1:0] instr_addr,
    input  logic [7:0]           byte_zero,
    input  logic [7:0]           byte_one,
    input  logic [7:0]           byte_two,
    input  logic [7:0]           byte_three,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 known_opcode,
    output logic [5:0]           mnemonic_index,
    output logic [2:0]           format_code,
    output logic [2:0]           instr_length,
    output logic [1:0]           operand_mode,
    output logic [2:0]           target_mode,
    output logic                 indexed,
    output logic [ADDR_BITS-1:0] target_address,
    output logic [3:0]           reg_one,
    output logic [3:0]           reg_two,
    output logic                 base_loaded
);

    // Input stage.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           b0_reg;
    logic [7:0]           b1_reg;
    logic [7:0]           b2_reg;
    logic [7:0]           b3_reg;

    // Result stage.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    sxd_pkg::decode_result_t res_reg;
    logic [ADDR_BITS-1:0]    ta_reg;

    // Architectural base register.
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] base_next;

    sxd_pkg::decode_result_t dec_res;
    logic [ADDR_BITS-1:0]    dec_ta;
    logic                    in_xfer;
    logic                    advance;

    sxd_decode #(
        .ADDR_BITS (ADDR_BITS)
    ) u_decode (
        .instr_addr     (addr_reg),
        .byte_zero      (b0_reg),
        .byte_one       (b1_reg),
        .byte_two       (b2_reg),
        .byte_three     (b3_reg),
        .base_value     (base_reg),
        .result         (dec_res),
        .target_address (dec_ta)
    );

    // The held instruction moves on whenever the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        base_next = (advance && dec_res.base_load) ? dec_ta : base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            addr_reg <= instr_addr;
            b0_reg   <= byte_zero;
            b1_reg   <= byte_one;
            b2_reg   <= byte_two;
            b3_reg   <= byte_three;
        end
        if (advance) begin
            res_reg <= dec_res;
            ta_reg  <= dec_ta;
        end
    end

    assign out_valid      = out_valid_reg;
    assign known_opcode   = res_reg.known;
    assign mnemonic_index = res_reg.mnemonic;
    assign format_code    = res_reg.format_code;
    assign instr_length   = res_reg.length;
    assign operand_mode   = res_reg.operand_mode;
    assign target_mode    = res_reg.target_mode;
    assign indexed        = res_reg.indexed;
    assign target_address = ta_reg;
    assign reg_one        = res_reg.reg_one;
    assign reg_two        = res_reg.reg_two;
    assign base_loaded    = res_reg.base_load;

`ifndef ASSERT_OFF
    // The base register only changes when an LDB leaves the input stage.
    a_base_update: assert property (@(posedge clk) disable iff (!rst_n)
        (base_reg != $past(base_reg)) |-> $past(advance && dec_res.base_load))
        else $error("base register changed without an LDB transfer");

    // An instruction that moves on always shows up as a result in the next cycle.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded instruction was lost");

    // A held instruction that cannot move on stays in the input stage.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a stalled instruction");

    // Only a known LDB may report a base load.
    a_ldb_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && base_loaded) |->
            (known_opcode && (mnemonic_index == sxd_pkg::LDB_INDEX)))
        else $error("base load reported for a non-LDB instruction");

    // An unknown opcode has no format and a length of one byte.
    a_unknown_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !known_opcode) |->
            ((instr_length == 3'd1) && (format_code == sxd_pkg::FORMAT_UNKNOWN)))
        else $error("unknown opcode reported with a format");
`endif

endmodule
